FILE: design/pldts_pkg.sv
// pldts_pkg: types and constants shared by the polyline segment decoder
// holds the header layout, flag bits and the segment beat structures
// no dependencies
`default_nettype none

package pldts_pkg;

    // header byte positions
    localparam logic [15:0] HDR_FLAGS    = 16'd0;
    localparam logic [15:0] HDR_BRIGHT   = 16'd1;
    localparam logic [15:0] HDR_ANCHX_HI = 16'd2;
    localparam logic [15:0] HDR_ANCHX_LO = 16'd3;
    localparam logic [15:0] HDR_ANCHY_HI = 16'd4;
    localparam logic [15:0] HDR_ANCHY_LO = 16'd5;
    localparam logic [15:0] HDR_COUNT_HI = 16'd6;
    localparam logic [15:0] HDR_COUNT_LO = 16'd7;
    localparam logic [18:0] HDR_LEN      = 19'd8;

    // flag bits of header byte 0
    localparam int FLAG_HAS_Z  = 0;
    localparam int FLAG_CLOSED = 1;
    localparam int FLAG_WIDE   = 2;

    // delta bytes per record
    localparam logic [2:0] DLEN_NARROW = 3'd2;
    localparam logic [2:0] DLEN_WIDE   = 3'd4;

    // one segment beat
    typedef struct packed {
        logic [11:0] sx;
        logic [11:0] sy;
        logic [11:0] ex;
        logic [11:0] ey;
        logic [7:0]  z;
        logic        last;
    } t_seg;

    // up to two segments caused by one payload byte, compacted from slot 0
    typedef struct packed {
        logic v0;
        logic v1;
        t_seg s0;
        t_seg s1;
    } t_push;

endpackage

`default_nettype wire

FILE: design/pldts_core.sv
// pldts_core: input register, header parser and delta accumulator
// turns one registered payload byte into up to two segments per cycle while the queue has room
// depends on pldts_pkg
`default_nettype none

module pldts_core
    import pldts_pkg::*;
#(
    parameter int COORD_MAX = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_first_byte,
    input  wire logic [15:0] i_payload_length,
    input  wire logic        i_room,
    output t_push            o_push
);

    localparam logic [31:0] CMAX32 = 32'(COORD_MAX);

    // clamp to 0..COORD_MAX, masked to device width
    function automatic logic [11:0] clamp12(input logic [31:0] v);
        logic [11:0] res;
        if (v[31]) begin
            res = 12'd0;
        end else if (v > CMAX32) begin
            res = CMAX32[11:0];
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

    // input beat register
    logic        r_v;
    logic [7:0]  r_byte;
    logic        r_first;
    logic [15:0] r_len;
    logic        adv;

    assign adv     = r_v && i_room;
    assign o_ready = !r_v || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_payload_byte;
            r_first <= i_first_byte;
            r_len   <= i_payload_length;
        end
    end

    // decoder state
    logic [15:0] r_byte_position, n_byte_position;
    logic [15:0] r_declared_length, n_declared_length;
    logic [2:0]  r_header_flags, n_header_flags;
    logic [7:0]  r_base_brightness, n_base_brightness;
    logic [15:0] r_anchor_x, n_anchor_x;
    logic [15:0] r_anchor_y, n_anchor_y;
    logic [15:0] r_points_left, n_points_left;
    logic        r_payload_valid, n_payload_valid;
    logic [31:0] r_record_bytes, n_record_bytes;
    logic [2:0]  r_record_index, n_record_index;
    logic [31:0] r_accum_x, n_accum_x;
    logic [31:0] r_accum_y, n_accum_y;
    logic [11:0] r_prev_x, n_prev_x;
    logic [11:0] r_prev_y, n_prev_y;

    // working values
    logic [15:0] pos0, dlen0, pleft0, count, cm1, pleft_dec;
    logic        pvalid0, active, wide, has_z, done;
    logic [31:0] rb0, rb_n, dx, dy, ax, ay;
    logic [2:0]  ri0, ri_inc, dlen;
    logic [18:0] need;
    logic [7:0]  z;
    logic [11:0] cx, cy, anc_cx, anc_cy;
    logic        seg_main, seg_close;
    t_seg        main_seg, close_seg;

    always_comb begin
        // a first byte restarts the payload
        pos0    = r_first ? 16'd0 : r_byte_position;
        dlen0   = r_first ? r_len : r_declared_length;
        pvalid0 = r_first ? 1'b0 : r_payload_valid;
        pleft0  = r_first ? 16'd0 : r_points_left;
        rb0     = r_first ? 32'd0 : r_record_bytes;
        ri0     = r_first ? 3'd0 : r_record_index;
        active  = pos0 < dlen0;

        wide   = r_header_flags[FLAG_WIDE];
        has_z  = r_header_flags[FLAG_HAS_Z];
        dlen   = wide ? DLEN_WIDE : DLEN_NARROW;
        anc_cx = clamp12({16'd0, r_anchor_x});
        anc_cy = clamp12({16'd0, r_anchor_y});

        // header length check, stride 2..5 by shift and add
        count = {pleft0[15:8], r_byte};
        cm1   = count - 16'd1;
        need  = HDR_LEN + (wide ? {1'b0, cm1, 2'b00} : {2'b00, cm1, 1'b0})
                + (has_z ? {3'b000, cm1} : 19'd0);

        // record byte assembly
        ri_inc = ri0 + 3'd1;
        done   = 1'b0;
        z      = r_base_brightness;
        rb_n   = rb0;
        if (ri0 < dlen) begin
            rb_n = {rb0[23:0], r_byte};
            done = (ri_inc == dlen) && !has_z;
        end else begin
            z    = r_byte;
            done = 1'b1;
        end
        if (wide) begin
            dx = {{16{rb_n[31]}}, rb_n[31:16]};
            dy = {{16{rb_n[15]}}, rb_n[15:0]};
        end else begin
            dx = {{24{rb_n[15]}}, rb_n[15:8]};
            dy = {{24{rb_n[7]}}, rb_n[7:0]};
        end
        ax        = r_accum_x + dx;
        ay        = r_accum_y + dy;
        cx        = clamp12(ax);
        cy        = clamp12(ay);
        pleft_dec = pleft0 - 16'd1;

        // defaults: hold, apart from restart clears
        n_byte_position   = pos0;
        n_declared_length = dlen0;
        n_header_flags    = r_header_flags;
        n_base_brightness = r_base_brightness;
        n_anchor_x        = r_anchor_x;
        n_anchor_y        = r_anchor_y;
        n_points_left     = pleft0;
        n_payload_valid   = pvalid0;
        n_record_bytes    = rb0;
        n_record_index    = ri0;
        n_accum_x         = r_accum_x;
        n_accum_y         = r_accum_y;
        n_prev_x          = r_prev_x;
        n_prev_y          = r_prev_y;
        seg_main          = 1'b0;
        seg_close         = 1'b0;

        if (active) begin
            n_byte_position = pos0 + 16'd1;
            case (pos0)
                HDR_FLAGS:    n_header_flags    = r_byte[2:0];
                HDR_BRIGHT:   n_base_brightness = r_byte;
                HDR_ANCHX_HI: n_anchor_x        = {r_byte, 8'd0};
                HDR_ANCHX_LO: n_anchor_x        = {r_anchor_x[15:8], r_byte};
                HDR_ANCHY_HI: n_anchor_y        = {r_byte, 8'd0};
                HDR_ANCHY_LO: n_anchor_y        = {r_anchor_y[15:8], r_byte};
                HDR_COUNT_HI: n_points_left     = {r_byte, 8'd0};
                HDR_COUNT_LO: begin
                    n_payload_valid = 1'b0;
                    n_points_left   = 16'd0;
                    if (count != 16'd0 && {3'b000, dlen0} >= need) begin
                        n_payload_valid = 1'b1;
                        n_points_left   = cm1;
                    end
                    n_accum_x      = {16'd0, r_anchor_x};
                    n_accum_y      = {16'd0, r_anchor_y};
                    n_prev_x       = anc_cx;
                    n_prev_y       = anc_cy;
                    n_record_bytes = 32'd0;
                    n_record_index = 3'd0;
                end
                default: begin
                    if (pvalid0 && pleft0 != 16'd0) begin
                        n_record_bytes = rb_n;
                        if (ri0 < dlen) begin
                            n_record_index = ri_inc;
                        end
                        if (done) begin
                            n_accum_x      = ax;
                            n_accum_y      = ay;
                            n_prev_x       = cx;
                            n_prev_y       = cy;
                            n_record_bytes = 32'd0;
                            n_record_index = 3'd0;
                            n_points_left  = pleft_dec;
                            seg_main       = z != 8'd0;
                            seg_close      = pleft_dec == 16'd0
                                             && r_header_flags[FLAG_CLOSED]
                                             && r_base_brightness != 8'd0;
                        end
                    end
                end
            endcase
        end

        // segment assembly, closing segment moves up when the main one is absent
        main_seg  = '{sx: r_prev_x, sy: r_prev_y, ex: cx, ey: cy, z: z,
                      last: !seg_close};
        close_seg = '{sx: cx, sy: cy, ex: anc_cx, ey: anc_cy,
                      z: r_base_brightness, last: 1'b1};
        o_push.v0 = adv && (seg_main || seg_close);
        o_push.v1 = adv && seg_main && seg_close;
        o_push.s0 = seg_main ? main_seg : close_seg;
        o_push.s1 = close_seg;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position   <= '0;
            r_declared_length <= '0;
            r_header_flags    <= '0;
            r_base_brightness <= '0;
            r_anchor_x        <= '0;
            r_anchor_y        <= '0;
            r_points_left     <= '0;
            r_payload_valid   <= 1'b0;
            r_record_bytes    <= '0;
            r_record_index    <= '0;
            r_accum_x         <= '0;
            r_accum_y         <= '0;
            r_prev_x          <= '0;
            r_prev_y          <= '0;
        end else if (adv) begin
            r_byte_position   <= n_byte_position;
            r_declared_length <= n_declared_length;
            r_header_flags    <= n_header_flags;
            r_base_brightness <= n_base_brightness;
            r_anchor_x        <= n_anchor_x;
            r_anchor_y        <= n_anchor_y;
            r_points_left     <= n_points_left;
            r_payload_valid   <= n_payload_valid;
            r_record_bytes    <= n_record_bytes;
            r_record_index    <= n_record_index;
            r_accum_x         <= n_accum_x;
            r_accum_y         <= n_accum_y;
            r_prev_x          <= n_prev_x;
            r_prev_y          <= n_prev_y;
        end
    end

endmodule

`default_nettype wire

FILE: design/pldts_outq.sv
// pldts_outq: four-entry result queue taking up to two segments a cycle
// drains one segment beat per cycle towards the output port while i_ready is high
// depends on pldts_pkg
`default_nettype none

module pldts_outq
    import pldts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_seg      o_seg
);

    t_seg       r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    // room for two more beats
    assign o_room  = r_cnt <= 3'd2;
    assign o_valid = r_cnt != 3'd0;
    assign o_seg   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    // pointer and fill count
    always_comb begin
        n_wp  = r_wp + {1'b0, i_push.v0} + {1'b0, i_push.v1};
        n_rp  = r_rp + {1'b0, pop};
        n_cnt = r_cnt + {2'b00, i_push.v0} + {2'b00, i_push.v1} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.s0;
        end
        if (i_push.v1) begin
            r_mem[r_wp + 2'd1] <= i_push.s1;
        end
    end

endmodule

`default_nettype wire

FILE: design/polyline_delta_to_segments.sv
// Polyline delta decoder: takes a polyline payload one byte per beat and
// returns line segments in clamped device coordinates. A beat is taken every
// cycle while no more than two segments wait in the four-entry output queue;
// a byte is registered in the input beat register, decoded, and its segments
// are written into the output queue once it has room and offered on the output
// from there. A byte causes at most two segments (the final record of a closed
// path), and each segment takes one output beat, so sustained input runs at one
// byte per cycle unless the output stalls.
// depends on pldts_pkg, pldts_core, pldts_outq
`default_nettype none

module polyline_delta_to_segments
    import pldts_pkg::*;
#(
    parameter int COORD_MAX = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_first_byte,
    input  wire logic [15:0] i_payload_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_start_x,
    output logic [11:0]      o_start_y,
    output logic [11:0]      o_end_x,
    output logic [11:0]      o_end_y,
    output logic [7:0]       o_intensity,
    output logic             o_last_of_run
);

    t_push push;
    t_seg  seg;
    logic  room;

    // decode stage
    pldts_core #(
        .COORD_MAX (COORD_MAX)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_payload_byte   (i_payload_byte),
        .i_first_byte     (i_first_byte),
        .i_payload_length (i_payload_length),
        .i_room           (room),
        .o_push           (push)
    );

    // result queue
    pldts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_seg   (seg)
    );

    assign o_start_x     = seg.sx;
    assign o_start_y     = seg.sy;
    assign o_end_x       = seg.ex;
    assign o_end_y       = seg.ey;
    assign o_intensity   = seg.z;
    assign o_last_of_run = seg.last;

endmodule

`default_nettype wire

FILE: verif/pldts_checker.sv
// pldts_checker: watches the byte and segment channels of the polyline decoder,
// predicts the segments of every accepted byte and compares them in order
// depends on pldts_pkg
module pldts_checker
    import pldts_pkg::*;
#(
    parameter int COORD_MAX = 4095
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_payload_length,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [11:0] i_start_x,
    input  logic [11:0] i_start_y,
    input  logic [11:0] i_end_x,
    input  logic [11:0] i_end_y,
    input  logic [7:0]  i_intensity,
    input  logic        i_last_of_run,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state as seen by the predictor
    logic [15:0] pos        = '0;
    logic [15:0] decl_len   = '0;
    logic [2:0]  hdr_flags  = '0;
    logic [7:0]  bright     = '0;
    logic [15:0] anc_x      = '0;
    logic [15:0] anc_y      = '0;
    logic [15:0] pts_left   = '0;
    logic        frame_ok   = 1'b0;
    logic [31:0] rec_bytes  = '0;
    logic [2:0]  rec_idx    = '0;
    logic [31:0] acc_x      = '0;
    logic [31:0] acc_y      = '0;
    logic [11:0] last_x     = '0;
    logic [11:0] last_y     = '0;

    // segments still owed by the block, oldest first
    t_seg segs_due[$];
    int   n_mismatch = 0;

    function automatic logic [11:0] clamp_coord(input logic [31:0] v);
        if (v[31]) return 12'd0;
        if (v > COORD_MAX) return 12'(COORD_MAX);
        return v[11:0];
    endfunction

    function automatic string seg_str(input t_seg s);
        return $sformatf("(%0d,%0d)->(%0d,%0d) z=%0d last=%0b",
                         s.sx, s.sy, s.ex, s.ey, s.z, s.last);
    endfunction

    task automatic note_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 10) $display("%0t ns: segment mismatch: %s", $time, msg);
    endtask

    // advance the decoder by one payload byte and queue the segments it causes
    task automatic decode_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
        logic [31:0] cnt;
        logic [31:0] stride;
        logic [31:0] need;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [2:0]  dlen;
        logic        rec_done;
        logic [7:0]  z;
        logic [11:0] cx;
        logic [11:0] cy;
        t_seg        segs[2];
        int          n;
        n = 0;
        if (first) begin
            pos      = '0;
            decl_len = len;
            frame_ok = 1'b0;
            pts_left = '0;
            rec_bytes = '0;
            rec_idx  = '0;
        end
        if (pos >= decl_len) return;
        case (pos)
            HDR_FLAGS:    hdr_flags = b[2:0];
            HDR_BRIGHT:   bright = b;
            HDR_ANCHX_HI: anc_x = {b, 8'h00};
            HDR_ANCHX_LO: anc_x[7:0] = b;
            HDR_ANCHY_HI: anc_y = {b, 8'h00};
            HDR_ANCHY_LO: anc_y[7:0] = b;
            HDR_COUNT_HI: pts_left = {b, 8'h00};
            HDR_COUNT_LO: begin
                // header complete: accept only if every record fits the length
                cnt    = {16'd0, pts_left[15:8], b};
                stride = 32'(hdr_flags[FLAG_WIDE] ? DLEN_WIDE : DLEN_NARROW)
                       + 32'(hdr_flags[FLAG_HAS_Z]);
                need   = 32'(HDR_LEN) + (cnt - 32'd1) * stride;
                frame_ok = (cnt != 0) && ({16'd0, decl_len} >= need);
                pts_left = frame_ok ? 16'(cnt - 32'd1) : 16'd0;
                acc_x  = {16'd0, anc_x};
                acc_y  = {16'd0, anc_y};
                last_x = clamp_coord(acc_x);
                last_y = clamp_coord(acc_y);
                rec_bytes = '0;
                rec_idx = '0;
            end
            default: begin
                if (frame_ok && pts_left != 0) begin
                    dlen = hdr_flags[FLAG_WIDE] ? DLEN_WIDE : DLEN_NARROW;
                    rec_done = 1'b0;
                    z = bright;
                    if (rec_idx < dlen) begin
                        rec_bytes = {rec_bytes[23:0], b};
                        rec_idx++;
                        rec_done = (rec_idx == dlen) && !hdr_flags[FLAG_HAS_Z];
                    end else begin
                        z = b;
                        rec_done = 1'b1;
                    end
                    if (rec_done) begin
                        if (hdr_flags[FLAG_WIDE]) begin
                            dx = {{16{rec_bytes[31]}}, rec_bytes[31:16]};
                            dy = {{16{rec_bytes[15]}}, rec_bytes[15:0]};
                        end else begin
                            dx = {{24{rec_bytes[15]}}, rec_bytes[15:8]};
                            dy = {{24{rec_bytes[7]}}, rec_bytes[7:0]};
                        end
                        acc_x = acc_x + dx;
                        acc_y = acc_y + dy;
                        cx = clamp_coord(acc_x);
                        cy = clamp_coord(acc_y);
                        // a zero intensity moves the beam without drawing
                        if (z != 0) begin
                            segs[n] = '{last_x, last_y, cx, cy, z, 1'b0};
                            n++;
                        end
                        last_x = cx;
                        last_y = cy;
                        rec_bytes = '0;
                        rec_idx = '0;
                        pts_left--;
                        // closed path returns to the anchor on its final record
                        if (pts_left == 0 && hdr_flags[FLAG_CLOSED] && bright != 0) begin
                            segs[n] = '{cx, cy, clamp_coord(anc_x), clamp_coord(anc_y),
                                        bright, 1'b0};
                            n++;
                        end
                    end
                end
            end
        endcase
        pos++;
        for (int i = 0; i < n; i++) begin
            segs[i].last = (i == n - 1);
            segs_due.push_back(segs[i]);
        end
    endtask

    // predict on byte beats, compare on segment beats
    always @(posedge i_clk) begin
        t_seg got;
        t_seg want;
        if (!i_rst_n) begin
            pos = '0;
            decl_len = '0;
            hdr_flags = '0;
            bright = '0;
            anc_x = '0;
            anc_y = '0;
            pts_left = '0;
            frame_ok = 1'b0;
            rec_bytes = '0;
            rec_idx = '0;
            acc_x = '0;
            acc_y = '0;
            last_x = '0;
            last_y = '0;
            segs_due.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decode_byte(i_payload_byte, i_first_byte, i_payload_length);
            if (i_out_valid && i_out_ready) begin
                got = '{i_start_x, i_start_y, i_end_x, i_end_y, i_intensity, i_last_of_run};
                if (segs_due.size() == 0) begin
                    note_mismatch({"unexpected ", seg_str(got)});
                end else begin
                    want = segs_due.pop_front();
                    if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
                        got.ey !== want.ey || got.z !== want.z || got.last !== want.last)
                        note_mismatch({"expected ", seg_str(want), " actual ", seg_str(got)});
                end
            end
        end
        o_mismatches <= n_mismatch;
        o_pending    <= segs_due.size();
    end

endmodule

FILE: verif/tb.sv
// tb: drives polyline payloads into the segment decoder and gives the verdict
// depends on pldts_pkg, polyline_delta_to_segments and pldts_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pldts_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int COORD_MAX      = 4095;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEM_TARGET    = 1700;
    localparam int IDLE_PCT       = 22;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;

    // header flag bytes
    localparam logic [7:0] F_Z      = 8'(1 << FLAG_HAS_Z);
    localparam logic [7:0] F_CLOSED = 8'(1 << FLAG_CLOSED);
    localparam logic [7:0] F_WIDE   = 8'(1 << FLAG_WIDE);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_payload_byte;
    logic        i_first_byte;
    logic [15:0] i_payload_length;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_start_x;
    logic [11:0] o_start_y;
    logic [11:0] o_end_x;
    logic [11:0] o_end_y;
    logic [7:0]  o_intensity;
    logic        o_last_of_run;

    int mismatches;
    int pending;
    int n_items     = 0;
    int n_cycles    = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold_req  = 1'b0;
    logic rx_hold_done = 1'b0;

    logic [7:0] frame_q[$];

    always #(CLK_HALF) i_clk = ~i_clk;

    polyline_delta_to_segments #(
        .COORD_MAX(COORD_MAX)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_payload_byte  (i_payload_byte),
        .i_first_byte    (i_first_byte),
        .i_payload_length(i_payload_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_start_x       (o_start_x),
        .o_start_y       (o_start_y),
        .o_end_x         (o_end_x),
        .o_end_y         (o_end_y),
        .o_intensity     (o_intensity),
        .o_last_of_run   (o_last_of_run)
    );

    pldts_checker #(
        .COORD_MAX(COORD_MAX)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_payload_byte  (i_payload_byte),
        .i_first_byte    (i_first_byte),
        .i_payload_length(i_payload_length),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_start_x       (o_start_x),
        .i_start_y       (o_start_y),
        .i_end_x         (o_end_x),
        .i_end_y         (o_end_y),
        .i_intensity     (o_intensity),
        .i_last_of_run   (o_last_of_run),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("polyline_delta_to_segments test failed");
            $finish;
        end
    end

    // segment receiver: random stalls, plus one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one byte beat and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_payload_byte   <= b;
        i_first_byte     <= first;
        i_payload_length <= len;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_items++;
    endtask

    // send the first nsend bytes of the frame, padding with random bytes
    task automatic send_frame(input logic [15:0] decl, input int nsend);
        while (frame_q.size() < nsend) frame_q.push_back(8'($urandom_range(255)));
        for (int i = 0; i < nsend; i++)
            send_byte(frame_q[i], i == 0, (i == 0) ? decl : 16'($urandom_range(65535)));
    endtask

    // load n bytes, first byte highest
    task automatic load_bytes(input logic [127:0] v, input int n);
        frame_q.delete();
        for (int i = n - 1; i >= 0; i--) frame_q.push_back(v[i*8 +: 8]);
    endtask

    function automatic logic [15:0] pick_anchor();
        return ($urandom_range(9) < 7) ? 16'($urandom_range(4095)) : 16'($urandom_range(65535));
    endfunction

    // header plus nrec records of random content
    task automatic make_frame(input logic [7:0] flags, input logic [7:0] bright,
                              input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] cnt, input int nrec);
        logic [15:0] d;
        logic [7:0]  r;
        load_bytes({flags, bright, ax, ay, cnt}, 8);
        for (int k = 0; k < nrec; k++) begin
            if (flags[FLAG_WIDE]) begin
                repeat (2) begin
                    r = 8'($urandom_range(255));
                    d = $urandom_range(1) ? {{8{r[7]}}, r} : 16'($urandom_range(65535));
                    frame_q.push_back(d[15:8]);
                    frame_q.push_back(d[7:0]);
                end
            end else begin
                frame_q.push_back(8'($urandom_range(255)));
                frame_q.push_back(8'($urandom_range(255)));
            end
            if (flags[FLAG_HAS_Z])
                frame_q.push_back(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        end
    endtask

    // mostly well-formed payloads, some rejected, short, cut or oversized
    task automatic random_frame();
        int kind;
        int nrec;
        int stride;
        int need;
        int decl;
        int nsend;
        logic [7:0]  flags;
        logic [7:0]  bright;
        logic [15:0] cnt;
        kind   = $urandom_range(99);
        flags  = 8'($urandom_range(255));
        bright = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        nrec   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
        cnt    = 16'(nrec + 1);
        stride = (flags[FLAG_WIDE] ? int'(DLEN_WIDE) : int'(DLEN_NARROW))
               + int'(flags[FLAG_HAS_Z]);
        need   = 8 + nrec * stride;
        decl   = need;
        nsend  = need;
        if (kind < 70) begin
            // well formed, sometimes with slack bytes
            if ($urandom_range(3) == 0) decl = need + $urandom_range(1, 3);
            nsend = decl;
        end else if (kind < 78) begin
            // declared length too short for the records
            decl = need - $urandom_range(1, stride);
            nsend = decl;
        end else if (kind < 84) begin
            // zero point count
            cnt = '0;
            decl = $urandom_range(8, need);
            nsend = decl;
        end else if (kind < 89) begin
            // header never completes
            decl = $urandom_range(1, 7);
            nsend = decl + $urandom_range(0, 3);
        end else if (kind < 95) begin
            // cut short by the next payload
            decl = $urandom_range(need, 65535);
            nsend = $urandom_range(1, need);
        end else begin
            // arbitrary count and length
            cnt = 16'($urandom_range(65535));
            decl = $urandom_range(65535);
            nsend = $urandom_range(8, need);
        end
        make_frame(flags, bright, pick_anchor(), pick_anchor(), cnt, nrec);
        send_frame(16'(decl), nsend);
        // stray bytes after a finished payload
        if (nsend >= decl && $urandom_range(9) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
    endtask

    // stop offering and wait for the block to empty
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_payload_byte   = '0;
        i_first_byte     = 1'b0;
        i_payload_length = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes before any payload are ignored
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'h00, 1'b0, 16'h0000);
        // zero declared length opens nothing
        send_byte(8'h5A, 1'b1, 16'd0);
        // narrow closed path from the origin, extreme deltas, zero and full intensity
        load_bytes({F_Z | F_CLOSED, 8'hFF, 48'h0000_0000_0003,
                    8'h80, 8'h7F, 8'hFF, 8'h7F, 8'h80, 8'h00}, 14);
        send_frame(16'd14, 14);
        // wide open path clamping both ways, unused flag bits set, slack bytes
        load_bytes({F_WIDE | 8'hF8, 8'h01, 32'h0800_0800, 16'd3,
                    32'h7FFF_8000, 32'h8000_7FFF}, 16);
        send_frame(16'd18, 18);
        // anchor at the top of the range, closed with zero base brightness
        load_bytes({F_WIDE | F_Z | F_CLOSED, 8'h00, 32'hFFFF_FFFF, 16'd2,
                    32'h0010_FFF0, 8'h40}, 13);
        send_frame(16'd13, 13);
        // new payload in the middle of a record abandons this one
        load_bytes({8'h00, 8'h33, 32'h0200_0200, 16'd3, 8'h10, 8'h10, 8'h20}, 11);
        send_frame(16'd12, 11);
        // zero point count
        load_bytes({8'h00, 8'h10, 32'h0001_0001, 16'd0, 16'h0101}, 10);
        send_frame(16'd10, 10);
        // length one byte short of the records
        load_bytes({8'h00, 8'h20, 32'h0100_0100, 16'd2, 8'h05}, 9);
        send_frame(16'd9, 9);
        // length under the header size
        load_bytes({8'h00, 8'h20, 32'h0100_0100, 16'd2}, 8);
        send_frame(16'd7, 8);
        // largest count and length cannot fit
        load_bytes({F_WIDE | F_Z, 8'hFF, 32'h0FFF_0FFF, 16'hFFFF, 16'h1234}, 10);
        send_frame(16'hFFFF, 10);

        // random payloads, first without idling on either side
        while (n_items < 400) random_frame();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        while (n_items < 900) random_frame();

        // long open path while the receiver holds off, so the block backs up
        rx_hold_req = 1'b1;
        make_frame(8'h00, 8'($urandom_range(1, 255)), pick_anchor(), pick_anchor(), 16'd41, 40);
        send_frame(16'd88, 88);
        wait_drain();

        while (n_items < ITEM_TARGET) random_frame();
        wait_drain();

        if (mismatches == 0 && pending == 0)
            $display("polyline_delta_to_segments test passed");
        else
            $display("polyline_delta_to_segments test failed");
        $finish;
    end

endmodule
